/* rtl/msbbp_pkg.sv */
// Shared types, constants and helpers of the MSB-first bit packer and unpacker.
package msbbp_pkg;

	localparam int STORE_BYTES    = 4096;
	localparam int MAX_FIELD_BITS = 32;
	localparam int ADDR_W         = $clog2(STORE_BYTES);
	localparam int WORD_W         = ADDR_W - 2;
	localparam int ROW_W          = WORD_W - 1;
	localparam int ROWS           = STORE_BYTES / 8;
	localparam int CFG_W          = 13;
	localparam int POS_W          = 16;
	localparam int CNT_W          = 16;

	typedef enum logic [3:0] {
		CMD_PUT     = 4'd0,
		CMD_GET     = 4'd1,
		CMD_PEEK    = 4'd2,
		CMD_SKIP    = 4'd3,
		CMD_SETPOS  = 4'd4,
		CMD_RESTART = 4'd5,
		CMD_CLEAR   = 4'd6,
		CMD_LOAD    = 4'd7,
		CMD_READ    = 4'd8
	} cmd_t;

	// One classified command waiting for the back end.
	typedef struct packed {
		cmd_t              op;
		logic [31:0]       bits;
		logic [CNT_W-1:0]  count;
		logic [POS_W-1:0]  new_pos;
		logic [ADDR_W-1:0] addr;
		logic              pre_ok;
	} entry_t;

	// Bytes of the store in use: register value clipped to the store size.
	function automatic logic [CFG_W-1:0] live_bytes(input logic [CFG_W-1:0] cfg);
		if (cfg > CFG_W'(STORE_BYTES)) begin
			return CFG_W'(STORE_BYTES);
		end
		return cfg;
	endfunction

endpackage

/* rtl/msb_first_bit_packer_unpacker.sv */
// Top level of the MSB-first bit packer and unpacker over a byte store.
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid, in_stall, command, bits, bit_count,    | beat in
//          | new_position, byte_address                       |
//  out     | out_valid, out_stall, value, accepted,           | beat out
//          | bit_position, used_bytes, remaining_bits         |
//  cfg     | cfg_write, cfg_data (buffer_bytes)               | write only
//
// Each command takes two steps in the back end: one to read the two store
// words a field can span (even and odd banks read in parallel), one to
// compute, write back (both words on a put, one byte on a load) and load
// the result register, waiting while an output stall holds the result.
// Clear (not restart) then sweeps the bytes in use to zero in 8-byte rows,
// rounded up and at least one. After reset a sweep zeroes all 512 rows of
// the store, stalling input. A two-entry queue decouples input from output.
module msb_first_bit_packer_unpacker import msbbp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [3:0]        command,
	input  logic [31:0]       bits,
	input  logic [CNT_W-1:0]  bit_count,
	input  logic [POS_W-1:0]  new_position,
	input  logic [ADDR_W-1:0] byte_address,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [31:0]       value,
	output logic              accepted,
	output logic [POS_W-1:0]  bit_position,
	output logic [CFG_W-1:0]  used_bytes,
	output logic [POS_W-1:0]  remaining_bits
);

	logic [CFG_W-1:0] buffer_bytes_q;
	logic [CFG_W-1:0] live;
	logic             push, pop, full, head_valid, init_busy;
	entry_t           push_entry, head;

	// Size register; the user changes it only while idle (unchecked).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_bytes_q <= CFG_W'(STORE_BYTES);
		end else if (cfg_write) begin
			buffer_bytes_q <= cfg_data;
		end
	end

	assign live = live_bytes(buffer_bytes_q);

	msbbp_front u_front (
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.bits         (bits),
		.bit_count    (bit_count),
		.new_position (new_position),
		.byte_address (byte_address),
		.live         (live),
		.full         (full),
		.init_busy    (init_busy),
		.push         (push),
		.entry        (push_entry)
	);

	msbbp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	msbbp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.live           (live),
		.head_valid     (head_valid),
		.head           (head),
		.pop            (pop),
		.init_busy      (init_busy),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.value          (value),
		.accepted       (accepted),
		.bit_position   (bit_position),
		.used_bytes     (used_bytes),
		.remaining_bits (remaining_bits)
	);

endmodule

/* rtl/msbbp_front.sv */
// Front end: accept command beats and classify them by the checks that need no position.
module msbbp_front import msbbp_pkg::*; (
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [3:0]        command,
	input  logic [31:0]       bits,
	input  logic [CNT_W-1:0]  bit_count,
	input  logic [POS_W-1:0]  new_position,
	input  logic [ADDR_W-1:0] byte_address,
	input  logic [CFG_W-1:0]  live,
	input  logic              full,
	input  logic              init_busy,
	output logic              push,
	output entry_t            entry
);

	logic len_ok;
	logic addr_ok;

	assign in_stall = full || init_busy;
	assign push     = in_valid && !in_stall;
	assign len_ok   = bit_count <= CNT_W'(MAX_FIELD_BITS);
	assign addr_ok  = {1'b0, byte_address} < live;

	always_comb begin
		entry.op      = cmd_t'(command);
		entry.bits    = bits;
		entry.count   = bit_count;
		entry.new_pos = new_position;
		entry.addr    = byte_address;
		unique case (command) inside
			CMD_PUT, CMD_GET, CMD_PEEK:                entry.pre_ok = len_ok;
			CMD_LOAD, CMD_READ:                        entry.pre_ok = addr_ok;
			CMD_SKIP, CMD_SETPOS, CMD_RESTART, CMD_CLEAR: entry.pre_ok = 1'b1;
			default:                                   entry.pre_ok = 1'b0;
		endcase
	end

endmodule

/* rtl/msbbp_queue.sv */
// Two-entry queue between the front end and the back end.
module msbbp_queue import msbbp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output logic   full,
	output logic   head_valid,
	output entry_t head
);

	entry_t     slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = count_q == 2'd2;
	assign head_valid = count_q != 2'd0;
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_entry;
	end

endmodule

/* rtl/msbbp_back.sv */
// Back end: position register, two word banks of the store, execution and result register.
module msbbp_back import msbbp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CFG_W-1:0]  live,
	input  logic              head_valid,
	input  entry_t            head,
	output logic              pop,
	output logic              init_busy,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [31:0]       value,
	output logic              accepted,
	output logic [POS_W-1:0]  bit_position,
	output logic [CFG_W-1:0]  used_bytes,
	output logic [POS_W-1:0]  remaining_bits
);

	typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_SWEEP} state_t;

	state_t            state_q;
	entry_t            cur_q;
	logic [POS_W-1:0]  pos_q;
	logic [WORD_W-1:0] word_q;
	logic [ROW_W-1:0]  row_q;
	logic [CFG_W-1:0]  limit_q;
	logic              init_q;

	logic [31:0] bank_e [ROWS];
	logic [31:0] bank_o [ROWS];
	logic [31:0] rd_e_q, rd_o_q;

	logic [WORD_W-1:0] word_d;
	logic [ROW_W-1:0]  rd_row_e, rd_row_o, row_e_held, row_o_held;
	logic [POS_W-1:0]  cap;
	logic              room, ok, free, fire, last_row;
	logic [POS_W-1:0]  npos;
	logic [31:0]       w0, w1, get_val, byte_val, mask, fld, nval;
	logic [63:0]       pair, shifted, place, npair;
	logic [5:0]        cnt6;
	logic [4:0]        offs;
	logic [6:0]        place_sh;
	logic              we_e, we_o;
	logic [ROW_W-1:0]  wr_row_e, wr_row_o;
	logic [31:0]       wd_e, wd_o;
	logic [3:0]        be_e, be_o, sweep_be_e, sweep_be_o;
	logic [CFG_W:0]    row_base;
	logic [POS_W:0]    pos_plus7;

	assign cap       = {live, 3'b000};
	assign init_busy = init_q;
	assign free      = !out_valid || !out_stall;
	assign fire      = (state_q == ST_EXEC) && free;
	assign pop       = (state_q == ST_IDLE) && head_valid;

	// Word that holds the first bit (or the addressed byte) of the head command.
	assign word_d = (head.op == CMD_LOAD || head.op == CMD_READ) ?
		head.addr[ADDR_W-1:2] : pos_q[WORD_W+4:5];

	// Even/odd banks: a field spans word w and w+1, one in each bank.
	assign rd_row_o   = word_d[WORD_W-1:1];
	assign rd_row_e   = word_d[0] ? word_d[WORD_W-1:1] + ROW_W'(1) : word_d[WORD_W-1:1];
	assign row_o_held = word_q[WORD_W-1:1];
	assign row_e_held = word_q[0] ? word_q[WORD_W-1:1] + ROW_W'(1) : word_q[WORD_W-1:1];

	always_ff @(posedge clk) begin
		rd_e_q <= bank_e[(state_q == ST_IDLE) ? rd_row_e : row_e_held];
		rd_o_q <= bank_o[(state_q == ST_IDLE) ? rd_row_o : row_o_held];
	end

	assign w0      = word_q[0] ? rd_o_q : rd_e_q;
	assign w1      = word_q[0] ? rd_e_q : rd_o_q;
	assign pair    = {w0, w1};
	assign offs    = pos_q[4:0];
	assign cnt6    = cur_q.count[5:0];
	assign shifted = pair << offs;
	assign get_val = shifted[63:32] >> (6'd32 - cnt6);
	assign mask    = ~(32'hFFFF_FFFF << cnt6);
	assign fld     = cur_q.bits & mask;
	assign place_sh = 7'd64 - {2'b00, offs} - {1'b0, cnt6};
	assign place   = {32'b0, fld} << place_sh;
	assign npair   = pair | place;
	assign byte_val = {24'b0, w0[31 - 8 * cur_q.addr[1:0] -: 8]};
	assign room    = ({1'b0, pos_q} + {1'b0, cur_q.count}) <= {1'b0, cap};

	always_comb begin
		ok   = 1'b0;
		npos = pos_q;
		nval = 32'b0;
		unique case (cur_q.op)
			CMD_PUT: begin
				ok = cur_q.pre_ok && room;
				if (ok) npos = pos_q + cur_q.count;
			end
			CMD_GET: begin
				ok = cur_q.pre_ok && room;
				if (ok) begin
					npos = pos_q + cur_q.count;
					nval = get_val;
				end
			end
			CMD_PEEK: begin
				ok = cur_q.pre_ok && room;
				if (ok) nval = get_val;
			end
			CMD_SKIP: begin
				ok = room;
				if (ok) npos = pos_q + cur_q.count;
			end
			CMD_SETPOS: begin
				ok = cur_q.new_pos <= cap;
				if (ok) npos = cur_q.new_pos;
			end
			CMD_RESTART, CMD_CLEAR: begin
				ok   = 1'b1;
				npos = '0;
			end
			CMD_LOAD: ok = cur_q.pre_ok;
			CMD_READ: begin
				ok = cur_q.pre_ok;
				if (ok) nval = byte_val;
			end
			default: ok = 1'b0;
		endcase
	end

	// Sweep byte enables: zero only bytes below the limit.
	assign row_base = {2'b00, row_q, 3'b000};
	assign last_row = (row_base + (CFG_W+1)'(8)) >= {1'b0, limit_q};
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			sweep_be_e[3-j] = (row_base + (CFG_W+1)'(j))     < {1'b0, limit_q};
			sweep_be_o[3-j] = (row_base + (CFG_W+1)'(j + 4)) < {1'b0, limit_q};
		end
	end

	always_comb begin
		we_e = 1'b0;
		we_o = 1'b0;
		wr_row_e = row_e_held;
		wr_row_o = row_o_held;
		wd_e = word_q[0] ? npair[31:0] : npair[63:32];
		wd_o = word_q[0] ? npair[63:32] : npair[31:0];
		be_e = 4'b1111;
		be_o = 4'b1111;
		if (state_q == ST_SWEEP) begin
			we_e = 1'b1;
			we_o = 1'b1;
			wr_row_e = row_q;
			wr_row_o = row_q;
			wd_e = '0;
			wd_o = '0;
			be_e = sweep_be_e;
			be_o = sweep_be_o;
		end else if (fire && ok && cur_q.op == CMD_PUT) begin
			we_e = 1'b1;
			we_o = 1'b1;
		end else if (fire && ok && cur_q.op == CMD_LOAD) begin
			we_e = !word_q[0];
			we_o = word_q[0];
			wr_row_e = word_q[WORD_W-1:1];
			wd_e = {4{cur_q.bits[7:0]}};
			wd_o = {4{cur_q.bits[7:0]}};
			be_e = 4'b1000 >> cur_q.addr[1:0];
			be_o = 4'b1000 >> cur_q.addr[1:0];
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 4; j++) begin
			if (we_e && be_e[j]) bank_e[wr_row_e][8*j +: 8] <= wd_e[8*j +: 8];
			if (we_o && be_o[j]) bank_o[wr_row_o][8*j +: 8] <= wd_o[8*j +: 8];
		end
	end

	assign pos_plus7 = {1'b0, npos} + (POS_W+1)'(7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_SWEEP;
			init_q    <= 1'b1;
			row_q     <= '0;
			limit_q   <= CFG_W'(STORE_BYTES);
			pos_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			// Drop the result once taken, unless a new one loads this cycle.
			if (out_valid && !out_stall && !fire) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						cur_q   <= head;
						word_q  <= word_d;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (free) begin
						pos_q          <= npos;
						out_valid      <= 1'b1;
						value          <= nval;
						accepted       <= ok;
						bit_position   <= npos;
						used_bytes     <= pos_plus7[CFG_W+2:3];
						remaining_bits <= (npos >= cap) ? '0 : cap - npos;
						if (cur_q.op == CMD_CLEAR) begin
							row_q   <= '0;
							limit_q <= live;
							state_q <= ST_SWEEP;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_SWEEP: begin
					row_q <= row_q + ROW_W'(1);
					if (last_row) begin
						init_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
